>>> hw/rtl/ist_pkg.sv
// ----------------------------------------------------------------------------
// ist_pkg
// Shared types and constants of the ISO-8601 date/timestamp parser: channel
// payloads and the command bundle from the sequencer to the datapath.
// ----------------------------------------------------------------------------
package ist_pkg;

   localparam int MAX_FRACTION_DIGITS = 6;

   // input transaction: one character of the string
   typedef struct packed {
      logic [7:0] char_code;
      logic       last_char;
   } req_type;

   // result transaction: days or microseconds since the epoch
   typedef struct packed {
      logic signed [58:0] value;
      logic               parse_error;
   } rsp_type;

   // one enable per datapath step
   typedef struct packed {
      logic char_en;
      logic era_en;
      logic yoe_en;
      logic doe_en;
      logic days_en;
      logic secs_en;
      logic lo_en;
      logic hi_en;
      logic sum_en;
      logic load_en;
   } dp_cmd_type;

endpackage

>>> hw/rtl/iso_timestamp_parser.sv
// ----------------------------------------------------------------------------
// iso_timestamp_parser
// Converts an ISO-8601 date or timestamp string, one character per
// transaction, into days or microseconds since 1970-01-01.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: one character per transaction; last_char marks the end of
//   the string. Characters are taken one per cycle while the block collects.
//   rsp channel: one result per string, carrying the value and parse_error
//   (value 0 on any format, length or range fault).
//   csr port: csr_we/csr_wdata write timestamp_form (1 = microseconds,
//   0 = date only in days); reset value is 1.
// Conversion:
//   after the last character is accepted, the sequencer runs eight
//   conversion steps of the shared datapath, then loads the result
//   register as soon as it is free; req_ready is low from the last
//   character until that load.
// Reset and stalls:
//   synchronous reset clears the accumulators, sets timestamp_form and
//   clears the result valid flag. A result held by a stalled receiver does
//   not stop the next string from being collected and converted; only the
//   final load waits for the result register to drain.
// ----------------------------------------------------------------------------
module iso_timestamp_parser (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  ist_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output ist_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic             csr_wdata
);

   ist_pkg::dp_cmd_type cmd;

   ist_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_last  (req_data.last_char),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   ist_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .cmd       (cmd),
      .rsp_data  (rsp_data)
   );

endmodule

>>> hw/rtl/ist_ctrl.sv
// ----------------------------------------------------------------------------
// ist_ctrl
// Sequencer: collects characters, then steps the datapath through the
// civil-days and microsecond conversion and owns the result valid flag.
// ----------------------------------------------------------------------------
module ist_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_last,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output ist_pkg::dp_cmd_type cmd
);

   localparam logic [3:0] ST_RECV   = 4'd0;
   localparam logic [3:0] ST_ERA    = 4'd1;
   localparam logic [3:0] ST_YOE    = 4'd2;
   localparam logic [3:0] ST_DOE    = 4'd3;
   localparam logic [3:0] ST_DAYS   = 4'd4;
   localparam logic [3:0] ST_SECS   = 4'd5;
   localparam logic [3:0] ST_MUL_LO = 4'd6;
   localparam logic [3:0] ST_MUL_HI = 4'd7;
   localparam logic [3:0] ST_SUM    = 4'd8;
   localparam logic [3:0] ST_DONE   = 4'd9;

   logic [3:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_RECV);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_RECV: begin
            cmd.char_en = req_valid;
            if (req_valid && req_last) begin
               state_in = ST_ERA;
            end
         end
         ST_ERA: begin
            cmd.era_en = 1'b1;
            state_in   = ST_YOE;
         end
         ST_YOE: begin
            cmd.yoe_en = 1'b1;
            state_in   = ST_DOE;
         end
         ST_DOE: begin
            cmd.doe_en = 1'b1;
            state_in   = ST_DAYS;
         end
         ST_DAYS: begin
            cmd.days_en = 1'b1;
            state_in    = ST_SECS;
         end
         ST_SECS: begin
            cmd.secs_en = 1'b1;
            state_in    = ST_MUL_LO;
         end
         ST_MUL_LO: begin
            cmd.lo_en = 1'b1;
            state_in  = ST_MUL_HI;
         end
         ST_MUL_HI: begin
            cmd.hi_en = 1'b1;
            state_in  = ST_SUM;
         end
         ST_SUM: begin
            cmd.sum_en = 1'b1;
            state_in   = ST_DONE;
         end
         ST_DONE: begin
            // wait here while the previous result is still held
            if (slot_free) begin
               cmd.load_en = 1'b1;
               state_in    = ST_RECV;
            end
         end
         default: begin
            state_in = ST_RECV;
         end
      endcase
   end

   always_comb begin
      priority if (cmd.load_en) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_RECV;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

>>> hw/rtl/ist_datapath.sv
// ----------------------------------------------------------------------------
// ist_datapath
// Character checker with field accumulators, the conversion registers of
// the civil-days and microsecond arithmetic, and the result register.
// ----------------------------------------------------------------------------
module ist_datapath (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_we,
   input  logic                csr_wdata,
   input  ist_pkg::req_type    req_data,
   input  ist_pkg::dp_cmd_type cmd,
   output ist_pkg::rsp_type    rsp_data
);

   localparam logic [4:0] FRAC_POS = 5'd20;
   localparam logic [4:0] LEN_MAX  = 5'(20 + ist_pkg::MAX_FRACTION_DIGITS);
   localparam logic [4:0] POS_SAT  = 5'd31;

   function automatic logic [6:0] acc10(input logic [6:0] acc, input logic [3:0] dg);
      acc10 = (acc << 3) + (acc << 1) + 7'(dg);
   endfunction

   function automatic logic [16:0] frac_weight(input logic [2:0] k);
      logic [16:0] w;
      unique case (k)
         3'd0:    w = 17'd100000;
         3'd1:    w = 17'd10000;
         3'd2:    w = 17'd1000;
         3'd3:    w = 17'd100;
         3'd4:    w = 17'd10;
         3'd5:    w = 17'd1;
         default: w = 17'd0;
      endcase
      frac_weight = w;
   endfunction

   // days before the first of the month, in a year starting in March
   function automatic logic [8:0] month_offset(input logic [3:0] m);
      logic [8:0] o;
      unique case (m)
         4'd3:    o = 9'd0;
         4'd4:    o = 9'd31;
         4'd5:    o = 9'd61;
         4'd6:    o = 9'd92;
         4'd7:    o = 9'd122;
         4'd8:    o = 9'd153;
         4'd9:    o = 9'd184;
         4'd10:   o = 9'd214;
         4'd11:   o = 9'd245;
         4'd12:   o = 9'd275;
         4'd1:    o = 9'd306;
         4'd2:    o = 9'd337;
         default: o = 9'd0;
      endcase
      month_offset = o;
   endfunction

   logic        form_ff;
   logic [4:0]  char_position_ff, char_position_in;
   logic        fault_seen_ff, fault_seen_in;
   logic [13:0] year_acc_ff, year_acc_in;
   logic [6:0]  month_acc_ff, month_acc_in;
   logic [6:0]  day_acc_ff, day_acc_in;
   logic [6:0]  hour_acc_ff, hour_acc_in;
   logic [6:0]  minute_acc_ff, minute_acc_in;
   logic [6:0]  second_acc_ff, second_acc_in;
   logic [19:0] fraction_acc_ff, fraction_acc_in;

   logic [7:0]  c;
   logic        is_digit;
   logic [3:0]  dg;
   logic        char_ok;
   logic [4:0]  frac_idx;
   logic [4:0]  pos;

   assign c        = req_data.char_code;
   assign pos      = char_position_ff;
   assign is_digit = (c >= 8'h30) && (c <= 8'h39);
   assign dg       = is_digit ? c[3:0] : 4'd0;
   assign frac_idx = pos - FRAC_POS;

   // per-character check and field accumulation
   always_comb begin
      char_position_in = char_position_ff;
      fault_seen_in    = fault_seen_ff;
      year_acc_in      = year_acc_ff;
      month_acc_in     = month_acc_ff;
      day_acc_in       = day_acc_ff;
      hour_acc_in      = hour_acc_ff;
      minute_acc_in    = minute_acc_ff;
      second_acc_in    = second_acc_ff;
      fraction_acc_in  = fraction_acc_ff;
      char_ok          = 1'b0;
      if (cmd.char_en) begin
         priority if (pos <= 5'd3) begin
            char_ok     = is_digit;
            year_acc_in = (year_acc_ff << 3) + (year_acc_ff << 1) + 14'(dg);
         end else if (pos == 5'd4 || pos == 5'd7) begin
            char_ok = (c == 8'h2D);
         end else if (pos == 5'd5 || pos == 5'd6) begin
            char_ok      = is_digit;
            month_acc_in = acc10(month_acc_ff, dg);
         end else if (pos == 5'd8 || pos == 5'd9) begin
            char_ok    = is_digit;
            day_acc_in = acc10(day_acc_ff, dg);
         end else if (!form_ff) begin
            char_ok = 1'b0;
         end else if (pos == 5'd10) begin
            char_ok = (c == 8'h20) || (c == 8'h54);
         end else if (pos == 5'd11 || pos == 5'd12) begin
            char_ok     = is_digit;
            hour_acc_in = acc10(hour_acc_ff, dg);
         end else if (pos == 5'd13 || pos == 5'd16) begin
            char_ok = (c == 8'h3A);
         end else if (pos == 5'd14 || pos == 5'd15) begin
            char_ok       = is_digit;
            minute_acc_in = acc10(minute_acc_ff, dg);
         end else if (pos == 5'd17 || pos == 5'd18) begin
            char_ok       = is_digit;
            second_acc_in = acc10(second_acc_ff, dg);
         end else if (pos == 5'd19) begin
            char_ok = (c == 8'h2E);
         end else if (pos < LEN_MAX) begin
            char_ok = is_digit;
            if (frac_idx < 5'd6) begin
               fraction_acc_in = fraction_acc_ff
                               + 20'(frac_weight(frac_idx[2:0]) * 17'(dg));
            end
         end else begin
            char_ok = 1'b0;
         end
         if (!char_ok) begin
            fault_seen_in = 1'b1;
         end
         if (pos != POS_SAT) begin
            char_position_in = pos + 5'd1;
         end
      end
      if (cmd.load_en) begin
         char_position_in = '0;
         fault_seen_in    = 1'b0;
         year_acc_in      = '0;
         month_acc_in     = '0;
         day_acc_in       = '0;
         hour_acc_in      = '0;
         minute_acc_in    = '0;
         second_acc_in    = '0;
         fraction_acc_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         form_ff          <= 1'b1;
         char_position_ff <= '0;
         fault_seen_ff    <= 1'b0;
         year_acc_ff      <= '0;
         month_acc_ff     <= '0;
         day_acc_ff       <= '0;
         hour_acc_ff      <= '0;
         minute_acc_ff    <= '0;
         second_acc_ff    <= '0;
         fraction_acc_ff  <= '0;
      end else begin
         if (csr_we) begin
            form_ff <= csr_wdata;
         end
         char_position_ff <= char_position_in;
         fault_seen_ff    <= fault_seen_in;
         year_acc_ff      <= year_acc_in;
         month_acc_ff     <= month_acc_in;
         day_acc_ff       <= day_acc_in;
         hour_acc_ff      <= hour_acc_in;
         minute_acc_ff    <= minute_acc_in;
         second_acc_ff    <= second_acc_in;
         fraction_acc_ff  <= fraction_acc_in;
      end
   end

   // conversion registers, all kept as two's complement bit vectors
   logic        err_ff, err_in;
   logic [14:0] ym_ff, ym_in;
   logic [5:0]  era_ff, era_in;
   logic [8:0]  doy_ff, doy_in;
   logic [26:0] era_prod;
   logic        range_bad;
   logic        len_bad;

   logic [14:0] era_ext15;
   logic [14:0] era400;
   logic [22:0] era_ext23;
   logic [8:0]  yoe_ff, yoe_in;
   logic [22:0] era_days_ff, era_days_in;

   logic [1:0]  cent;
   logic [17:0] doe_ff, doe_in;
   logic [22:0] days_ff, days_in;
   logic [16:0] tod_ff, tod_in;
   logic [38:0] days_ext39;
   logic [38:0] secs_ff, secs_in;
   logic [39:0] lo_prod_ff, lo_prod_in;
   logic [38:0] hi_ext;
   logic [38:0] hi_prod_ff, hi_prod_in;
   logic [58:0] usec_ff, usec_in;
   ist_pkg::rsp_type rsp_ff, rsp_in;

   always_comb begin
      range_bad = (month_acc_ff < 7'd1) || (month_acc_ff > 7'd12)
               || (day_acc_ff < 7'd1) || (day_acc_ff > 7'd31);
      if (form_ff) begin
         len_bad = (char_position_ff < 5'd19) || (char_position_ff > LEN_MAX)
                || (hour_acc_ff > 7'd23) || (minute_acc_ff > 7'd59)
                || (second_acc_ff > 7'd59);
      end else begin
         len_bad = (char_position_ff != 5'd10);
      end
      err_in = fault_seen_ff || range_bad || len_bad;

      // the year counts from March, so January and February belong to the last one
      ym_in    = 15'(year_acc_ff) - ((month_acc_ff <= 7'd2) ? 15'd1 : 15'd0);
      // floor(y / 400) by reciprocal, exact for y below 10000
      era_prod = ym_in[13:0] * 13'd5243;
      era_in   = ym_in[14] ? 6'h3F : era_prod[26:21];
      doy_in   = month_offset(month_acc_ff[3:0]) + 9'(day_acc_ff) - 9'd1;
   end

   always_comb begin
      era_ext15   = {{9{era_ff[5]}}, era_ff};
      era400      = (era_ext15 << 8) + (era_ext15 << 7) + (era_ext15 << 4);
      yoe_in      = 9'(ym_ff - era400);
      era_ext23   = {{17{era_ff[5]}}, era_ff};
      era_days_in = 23'(era_ext23 * 23'd146097);
   end

   always_comb begin
      priority if (yoe_ff >= 9'd300) begin
         cent = 2'd3;
      end else if (yoe_ff >= 9'd200) begin
         cent = 2'd2;
      end else if (yoe_ff >= 9'd100) begin
         cent = 2'd1;
      end else begin
         cent = 2'd0;
      end
      doe_in = 18'(yoe_ff) * 18'd365 + 18'(yoe_ff >> 2) - 18'(cent) + 18'(doy_ff);
   end

   always_comb begin
      days_in    = era_days_ff + 23'(doe_ff) - 23'd719468;
      tod_in     = 17'(hour_acc_ff) * 17'd3600 + 17'(minute_acc_ff) * 17'd60
                 + 17'(second_acc_ff);
      days_ext39 = {{16{days_ff[22]}}, days_ff};
      secs_in    = 39'(days_ext39 * 39'd86400) + 39'(tod_ff);
      lo_prod_in = 40'(secs_ff[19:0]) * 40'd1000000;
      hi_ext     = {{20{secs_ff[38]}}, secs_ff[38:20]};
      hi_prod_in = 39'(hi_ext * 39'd1000000);
      usec_in    = {hi_prod_ff, 20'd0} + 59'(lo_prod_ff) + 59'(fraction_acc_ff);
   end

   always_comb begin
      rsp_in = rsp_ff;
      if (cmd.load_en) begin
         rsp_in.parse_error = err_ff;
         priority if (err_ff) begin
            rsp_in.value = '0;
         end else if (form_ff) begin
            rsp_in.value = usec_ff;
         end else begin
            rsp_in.value = {{36{days_ff[22]}}, days_ff};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.era_en) begin
         err_ff <= err_in;
         ym_ff  <= ym_in;
         era_ff <= era_in;
         doy_ff <= doy_in;
      end
      if (cmd.yoe_en) begin
         yoe_ff      <= yoe_in;
         era_days_ff <= era_days_in;
      end
      if (cmd.doe_en) begin
         doe_ff <= doe_in;
      end
      if (cmd.days_en) begin
         days_ff <= days_in;
         tod_ff  <= tod_in;
      end
      if (cmd.secs_en) begin
         secs_ff <= secs_in;
      end
      if (cmd.lo_en) begin
         lo_prod_ff <= lo_prod_in;
      end
      if (cmd.hi_en) begin
         hi_prod_ff <= hi_prod_in;
      end
      if (cmd.sum_en) begin
         usec_ff <= usec_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_data = rsp_ff;

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for iso_timestamp_parser. Strings are sent one character
// per transaction: first a directed table of date and timestamp strings, then
// random strings, mostly well-formed with random fields and some corrupted or
// pure noise. The timestamp_form register is changed between phases, sometimes
// in the middle of a string. Each result is checked against a table value or a predictor.
// ----------------------------------------------------------------------------
module testbench;

   localparam int CLOCK_PERIOD   = 12;
   localparam int RESET_CYCLES   = 5;
   localparam int CONVERT_CYCLES = 10;
   localparam int RANDOM_ITEMS   = 1150;
   localparam int QUIET_FROM     = 1100;
   localparam int QUIET_TO       = 1500;
   localparam int LIMIT_CYCLES   = 400000;
   localparam int REPORT_LIMIT   = 10;

   localparam longint USEC_PER_DAY    = 64'sd86400000000;
   localparam longint USEC_PER_HOUR   = 64'sd3600000000;
   localparam longint USEC_PER_MINUTE = 64'sd60000000;
   localparam longint USEC_PER_SECOND = 64'sd1000000;
   localparam int     FIRST_FRAC_WEIGHT = 100000;

   localparam logic FORM_DATE      = 1'b0;
   localparam logic FORM_TIMESTAMP = 1'b1;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   ist_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   ist_pkg::rsp_type rsp_data;
   logic             csr_we = 1'b0;
   logic             csr_wdata = FORM_TIMESTAMP;

   // predictor state
   logic        form_model = FORM_TIMESTAMP;
   logic [4:0]  char_pos = '0;
   logic        char_fault = 1'b0;
   logic [13:0] year_digits = '0;
   logic [6:0]  month_digits = '0;
   logic [6:0]  day_digits = '0;
   logic [6:0]  hour_digits = '0;
   logic [6:0]  minute_digits = '0;
   logic [6:0]  second_digits = '0;
   logic [19:0] frac_usec = '0;

   ist_pkg::rsp_type expected_epochs[$];
   logic [7:0]       text_bytes[$];

   // directed table
   logic             row_form[$];
   string            row_text[$];
   int               row_switch[$];
   bit               row_typed[$];
   ist_pkg::rsp_type row_result[$];

   bit               use_typed = 1'b0;
   ist_pkg::rsp_type typed_result = '0;
   bit               quiet_stretch = 1'b0;
   bit               random_phase = 1'b0;
   int               item_count = 0;
   int               next_phase_at = 0;
   int               mismatch_count = 0;
   int               cycle_count = 0;
   ist_pkg::rsp_type got_epoch;
   ist_pkg::rsp_type want_epoch;

   iso_timestamp_parser dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // proleptic Gregorian day count relative to 1970-01-01
   function automatic longint days_since_epoch(longint y, int m, int d);
      longint era, yoe, doy, doe;
      if (m <= 2) y = y - 1;
      era = (y >= 0 ? y : y - 399) / 400;
      yoe = y - era * 400;
      doy = (153 * (m + (m > 2 ? -3 : 9)) + 2) / 5 + d - 1;
      doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
      return era * 146097 + doe - 719468;
   endfunction

   function automatic void parse_iso_char(input ist_pkg::req_type item, output bit done,
                                          output ist_pkg::rsp_type result);
      logic [7:0]  ch;
      bit          is_digit, ok, err;
      int unsigned dg, k, weight;
      longint      epoch;
      ch = item.char_code;
      is_digit = (ch >= "0") && (ch <= "9");
      dg = is_digit ? ch - "0" : 0;
      done = 1'b0;
      result = '0;
      epoch = 0;
      if (char_pos <= 3) begin
         ok = is_digit;
         year_digits = 14'(year_digits * 10 + dg);
      end else if (char_pos == 4 || char_pos == 7) begin
         ok = (ch == "-");
      end else if (char_pos == 5 || char_pos == 6) begin
         ok = is_digit;
         month_digits = 7'(month_digits * 10 + dg);
      end else if (char_pos == 8 || char_pos == 9) begin
         ok = is_digit;
         day_digits = 7'(day_digits * 10 + dg);
      end else if (form_model == FORM_DATE) begin
         ok = 1'b0;
      end else if (char_pos == 10) begin
         ok = (ch == " ") || (ch == "T");
      end else if (char_pos == 11 || char_pos == 12) begin
         ok = is_digit;
         hour_digits = 7'(hour_digits * 10 + dg);
      end else if (char_pos == 13 || char_pos == 16) begin
         ok = (ch == ":");
      end else if (char_pos == 14 || char_pos == 15) begin
         ok = is_digit;
         minute_digits = 7'(minute_digits * 10 + dg);
      end else if (char_pos == 17 || char_pos == 18) begin
         ok = is_digit;
         second_digits = 7'(second_digits * 10 + dg);
      end else if (char_pos == 19) begin
         ok = (ch == ".");
      end else if (char_pos < 20 + ist_pkg::MAX_FRACTION_DIGITS) begin
         k = char_pos - 20;
         ok = is_digit;
         // each fraction digit weighs a tenth of the one before, none past six
         if (k < 6) begin
            weight = FIRST_FRAC_WEIGHT;
            repeat (k) weight = weight / 10;
            frac_usec = 20'(frac_usec + dg * weight);
         end
      end else begin
         ok = 1'b0;
      end
      if (!ok) char_fault = 1'b1;
      if (char_pos < 31) char_pos = char_pos + 1;

      if (item.last_char) begin
         done = 1'b1;
         err = char_fault;
         if (month_digits < 1 || month_digits > 12 || day_digits < 1 || day_digits > 31)
            err = 1'b1;
         if (form_model == FORM_DATE) begin
            if (char_pos != 10) err = 1'b1;
            if (!err) epoch = days_since_epoch(year_digits, month_digits, day_digits);
         end else begin
            if (char_pos < 19 || char_pos > 20 + ist_pkg::MAX_FRACTION_DIGITS) err = 1'b1;
            if (hour_digits > 23 || minute_digits > 59 || second_digits > 59) err = 1'b1;
            if (!err)
               epoch = days_since_epoch(year_digits, month_digits, day_digits) * USEC_PER_DAY
                     + longint'(hour_digits) * USEC_PER_HOUR
                     + longint'(minute_digits) * USEC_PER_MINUTE
                     + longint'(second_digits) * USEC_PER_SECOND
                     + longint'(frac_usec);
         end
         result.value = err ? '0 : epoch[58:0];
         result.parse_error = err;
         char_pos = '0;
         char_fault = 1'b0;
         year_digits = '0;
         month_digits = '0;
         day_digits = '0;
         hour_digits = '0;
         minute_digits = '0;
         second_digits = '0;
         frac_usec = '0;
      end
   endfunction

   task automatic send_char(input ist_pkg::req_type item);
      bit               done;
      ist_pkg::rsp_type result;
      @(negedge clock);
      quiet_stretch = (item_count >= QUIET_FROM) && (item_count < QUIET_TO);
      while (!quiet_stretch && $urandom_range(99) < 13) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      item_count++;
      parse_iso_char(item, done, result);
      if (done) expected_epochs.push_back(use_typed ? typed_result : result);
   endtask

   // hold off the sender until every result is back and the datapath is quiet
   task automatic wait_for_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_epochs.size() != 0) @(negedge clock);
      repeat (CONVERT_CYCLES + 6) @(negedge clock);
   endtask

   task automatic write_form(input logic form);
      wait_for_results();
      csr_we <= 1'b1;
      csr_wdata <= form;
      form_model = form;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic send_text(input int switch_at);
      int count;
      count = text_bytes.size();
      for (int i = 0; i < count; i++) begin
         if (switch_at != 0 && i == switch_at) write_form(~form_model);
         if (random_phase && item_count >= next_phase_at) begin
            write_form(1'($urandom_range(1)));
            next_phase_at = item_count + $urandom_range(150, 400);
         end
         send_char('{char_code: text_bytes[i], last_char: (i == count - 1)});
      end
      text_bytes.delete();
   endtask

   task automatic add_row(input logic form, input string text, input int switch_at,
                          input bit typed, input longint value, input bit err);
      row_form.push_back(form);
      row_text.push_back(text);
      row_switch.push_back(switch_at);
      row_typed.push_back(typed);
      row_result.push_back('{value: value[58:0], parse_error: err});
   endtask

   // mostly in range, now and then any two-digit value
   function automatic int pick_field(input int lo, input int hi);
      if ($urandom_range(9) == 0) return $urandom_range(99);
      return $urandom_range(hi, lo);
   endfunction

   task automatic make_random_text();
      string s;
      int    roll, yr, shape, cut;
      roll = $urandom_range(99);
      if (roll < 8) begin
         repeat ($urandom_range(34, 1)) text_bytes.push_back(8'($urandom_range(255)));
      end else begin
         if ($urandom_range(9) == 0) yr = $urandom_range(1) ? 9999 : 0;
         else yr = $urandom_range(9999);
         s = $sformatf("%04d-%02d-%02d", yr, pick_field(1, 12), pick_field(1, 31));
         if (form_model == FORM_TIMESTAMP || roll < 14) begin
            if ($urandom_range(1)) s = {s, "T"};
            else s = {s, " "};
            s = {s, $sformatf("%02d:%02d:%02d", pick_field(0, 23), pick_field(0, 59),
                              pick_field(0, 59))};
            shape = $urandom_range(8);
            if (shape != 0) s = {s, "."};
            for (int i = 1; i < shape; i++) s = {s, $sformatf("%0d", $urandom_range(9))};
         end
         for (int i = 0; i < s.len(); i++) text_bytes.push_back(s[i]);
         if (roll < 22) begin
            case ($urandom_range(2))
               0: begin
                  text_bytes[$urandom_range(text_bytes.size() - 1)] = 8'($urandom_range(255));
               end
               1: begin
                  cut = $urandom_range(5, 1);
                  repeat (cut) if (text_bytes.size() > 1) void'(text_bytes.pop_back());
               end
               default: begin
                  repeat ($urandom_range(12, 1))
                     text_bytes.push_back(8'($urandom_range(9)) + "0");
               end
            endcase
         end
      end
   endtask

   always @(negedge clock) begin
      rsp_ready <= quiet_stretch || ($urandom_range(99) >= 13);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         got_epoch = rsp_data;
         if (expected_epochs.size() == 0) begin
            if (mismatch_count < REPORT_LIMIT)
               $display("%0t: result with nothing expected: value %0d error %0b", $realtime,
                        $signed(got_epoch.value), got_epoch.parse_error);
            mismatch_count++;
         end else begin
            want_epoch = expected_epochs.pop_front();
            if (got_epoch.value !== want_epoch.value ||
                got_epoch.parse_error !== want_epoch.parse_error) begin
               if (mismatch_count < REPORT_LIMIT)
                  $display("%0t: value exp %0d got %0d, error exp %0b got %0b", $realtime,
                           $signed(want_epoch.value), $signed(got_epoch.value),
                           want_epoch.parse_error, got_epoch.parse_error);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      int directed_items;
      // timestamp form right after reset
      add_row(FORM_TIMESTAMP, "1970-01-01T00:00:00", 0, 1, 0, 0);
      add_row(FORM_TIMESTAMP, "1970-01-01 00:00:00.", 0, 1, 0, 0);
      add_row(FORM_TIMESTAMP, "9999-12-31T23:59:59.999999", 0, 1,
              64'sd253402300799999999, 0);
      add_row(FORM_TIMESTAMP, "0000-01-01 00:00:00.000000", 0, 1,
              -64'sd62167219200000000, 0);
      add_row(FORM_TIMESTAMP, "1970-01-01T00:00:00.0000001", 0, 1, 0, 1);
      add_row(FORM_TIMESTAMP, "2023-02-31T12:34:56.5", 0, 0, 0, 0);
      add_row(FORM_TIMESTAMP, "2024-13-01T00:00:00", 0, 1, 0, 1);
      add_row(FORM_TIMESTAMP, "2024-00-10T00:00:00", 0, 1, 0, 1);
      add_row(FORM_TIMESTAMP, "2024-01-00T00:00:00", 0, 1, 0, 1);
      add_row(FORM_TIMESTAMP, "2024-01-32T00:00:00", 0, 1, 0, 1);
      add_row(FORM_TIMESTAMP, "2024-06-15T24:00:00", 0, 1, 0, 1);
      add_row(FORM_TIMESTAMP, "2024-06-15T23:60:00", 0, 1, 0, 1);
      add_row(FORM_TIMESTAMP, "2024-06-15T23:59:60", 0, 1, 0, 1);
      add_row(FORM_TIMESTAMP, "2024-06-15X12:00:00", 0, 1, 0, 1);
      add_row(FORM_TIMESTAMP, "2024-06-15T12:00", 0, 1, 0, 1);
      add_row(FORM_TIMESTAMP, "1999-12-31 23:59:59.12", 0, 0, 0, 0);
      add_row(FORM_TIMESTAMP, "Z", 0, 1, 0, 1);
      // past 31 characters the position counter saturates
      add_row(FORM_TIMESTAMP, "2024-06-15T12:00:00.1234567890120123456789", 0, 1, 0, 1);
      add_row(FORM_DATE, "1970-01-01", 0, 1, 0, 0);
      add_row(FORM_DATE, "9999-12-31", 0, 1, 2932896, 0);
      add_row(FORM_DATE, "0000-01-01", 0, 1, -719528, 0);
      add_row(FORM_DATE, "2024-04-31", 0, 0, 0, 0);
      add_row(FORM_DATE, "2000-02-29", 0, 0, 0, 0);
      add_row(FORM_DATE, "2024-04-30T", 0, 1, 0, 1);
      // form flipped in the middle of a string
      add_row(FORM_DATE, "2024-05-06T07:08:09", 10, 0, 0, 0);
      add_row(FORM_TIMESTAMP, "2024-05-06", 5, 0, 0, 0);

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int r = 0; r < row_text.size(); r++) begin
         if (row_form[r] != form_model) write_form(row_form[r]);
         for (int i = 0; i < row_text[r].len(); i++) text_bytes.push_back(row_text[r][i]);
         use_typed = row_typed[r];
         typed_result = row_result[r];
         send_text(row_switch[r]);
         use_typed = 1'b0;
      end

      directed_items = item_count;
      random_phase = 1'b1;
      next_phase_at = item_count + $urandom_range(150, 400);
      while (item_count < directed_items + RANDOM_ITEMS) begin
         make_random_text();
         send_text(0);
      end
      // end with one more string, a single character that parses with an error
      text_bytes.push_back("0");
      random_phase = 1'b0;
      send_text(0);

      wait_for_results();
      repeat (CONVERT_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_epochs.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
